// ===== sv/rlba_pkg.sv =====
// ----------------------------------------------------------------------------
// RGB level adjuster package
// Shared widths, codes, reset values and structure types for the RGB level
// button adjuster.
// ----------------------------------------------------------------------------
package rlba_pkg;

    // Timing of the button auto-repeat and width of the hold counters.
    localparam int REPEAT_PERIOD   = 12;
    localparam int HOLD_COUNT_BITS = 16;
    localparam int PHASE_BITS      = (REPEAT_PERIOD > 1) ? $clog2(REPEAT_PERIOD) : 1;

    localparam int LEVEL_BITS    = 8;
    localparam int MODE_BITS     = 2;
    localparam int ACCEL_BITS    = 16;
    localparam int STEP_BITS     = 8;
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 16;
    // Common width for comparing a hold count with the acceleration threshold.
    localparam int CMP_BITS      = (HOLD_COUNT_BITS > ACCEL_BITS) ? HOLD_COUNT_BITS
                                                                   : ACCEL_BITS;

    localparam logic [LEVEL_BITS-1:0] LEVEL_MAX       = 8'd255;
    localparam logic [ACCEL_BITS-1:0] ACCEL_RESET     = 16'd1220;
    localparam logic [STEP_BITS-1:0]  FAST_STEP_RESET = 8'd5;

    // Selected channel codes.
    localparam logic [MODE_BITS-1:0] MODE_NONE  = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_RED   = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_GREEN = 2'd2;
    localparam logic [MODE_BITS-1:0] MODE_BLUE  = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_ACCEL_AFTER = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FAST_STEP   = 1'd1;

    typedef struct packed {
        logic [ACCEL_BITS-1:0] accel_after;
        logic [STEP_BITS-1:0]  fast_step;
    } t_cfg;

    // Hold counter with its position inside the repeat period.
    typedef struct packed {
        logic [HOLD_COUNT_BITS-1:0] count;
        logic [PHASE_BITS-1:0]      phase;
    } t_hold;

    typedef struct packed {
        logic mode_button;
        logic up_button;
        logic down_button;
    } t_btn;

    typedef struct packed {
        logic [LEVEL_BITS-1:0] red_level;
        logic [LEVEL_BITS-1:0] green_level;
        logic [LEVEL_BITS-1:0] blue_level;
        logic [MODE_BITS-1:0]  selected_channel;
        logic                  refresh_display;
        logic                  save_values;
    } t_lvl_item;

endpackage

// ===== sv/rlba_btn_if.sv =====
// ----------------------------------------------------------------------------
// Button tick channel
// Valid/ready channel carrying one timer tick with three button levels.
// ----------------------------------------------------------------------------
interface rlba_btn_if;
    logic valid;
    logic ready;
    logic mode_button;
    logic up_button;
    logic down_button;

    modport source (output valid, output mode_button, output up_button,
                    output down_button, input ready);
    modport sink   (input valid, input mode_button, input up_button,
                    input down_button, output ready);
endinterface

// ===== sv/rlba_lvl_if.sv =====
// ----------------------------------------------------------------------------
// Level result channel
// Valid/ready channel carrying the levels, mode and strobes of one tick.
// ----------------------------------------------------------------------------
interface rlba_lvl_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_level;
    logic [7:0] green_level;
    logic [7:0] blue_level;
    logic [1:0] selected_channel;
    logic       refresh_display;
    logic       save_values;

    modport source (output valid, output red_level, output green_level,
                    output blue_level, output selected_channel,
                    output refresh_display, output save_values, input ready);
    modport sink   (input valid, input red_level, input green_level,
                    input blue_level, input selected_channel,
                    input refresh_display, input save_values, output ready);
endinterface

// ===== sv/rlba_cfg.sv =====
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the acceleration threshold and the fast step, written by index.
// ----------------------------------------------------------------------------
module rlba_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [rlba_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [rlba_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    output rlba_pkg::t_cfg                      o_cfg
);
    import rlba_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.accel_after <= ACCEL_RESET;
            r_cfg.fast_step   <= FAST_STEP_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ACCEL_AFTER: r_cfg.accel_after <= i_cfg_data[ACCEL_BITS-1:0];
                CFG_FAST_STEP:   r_cfg.fast_step   <= i_cfg_data[STEP_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== sv/rlba_adjust.sv =====
// ----------------------------------------------------------------------------
// Adjust button handler
// Runs one hold counter (cleared on release) and applies a repeat step to a level.
// ----------------------------------------------------------------------------
module rlba_adjust (
    input  logic                              i_pressed,
    input  logic                              i_dir_up,
    input  rlba_pkg::t_hold                   i_hold,
    input  logic [rlba_pkg::LEVEL_BITS-1:0]   i_level,
    input  rlba_pkg::t_cfg                    i_cfg,
    output rlba_pkg::t_hold                   o_hold,
    output logic [rlba_pkg::LEVEL_BITS-1:0]   o_level,
    output logic                              o_repeat
);
    import rlba_pkg::*;

    logic [HOLD_COUNT_BITS-1:0] cnt_inc;
    logic [PHASE_BITS-1:0]      phase_inc;
    logic [STEP_BITS-1:0]       step;
    logic [LEVEL_BITS:0]        sum;
    logic                       up_ok;
    logic                       dn_ok;

    // The phase tracks the count modulo the repeat period; it restarts when
    // the count wraps so that the two never drift apart.
    always_comb begin
        cnt_inc = i_hold.count + HOLD_COUNT_BITS'(1);
        if (cnt_inc == '0) begin
            phase_inc = '0;
        end else if (i_hold.phase == PHASE_BITS'(REPEAT_PERIOD - 1)) begin
            phase_inc = '0;
        end else begin
            phase_inc = i_hold.phase + PHASE_BITS'(1);
        end

        step  = (CMP_BITS'(cnt_inc) > CMP_BITS'(i_cfg.accel_after)) ? i_cfg.fast_step
                                                                      : STEP_BITS'(1);
        sum   = {1'b0, i_level} + {1'b0, step};
        up_ok = (sum <= {1'b0, LEVEL_MAX});
        dn_ok = (i_level >= step);

        o_level = i_level;
        if (!i_pressed) begin
            o_hold   = '0;
            o_repeat = 1'b0;
        end else begin
            o_hold.count = cnt_inc;
            o_hold.phase = phase_inc;
            o_repeat     = (phase_inc == '0);
            if (o_repeat) begin
                if (i_dir_up && up_ok) begin
                    o_level = sum[LEVEL_BITS-1:0];
                end else if (!i_dir_up && dn_ok) begin
                    o_level = i_level - step;
                end
            end
        end
    end

endmodule

// ===== sv/rgb_level_button_adjuster_unit.sv =====
// ----------------------------------------------------------------------------
// RGB level button adjuster
// Turns button ticks into red, green and blue levels with auto-repeat.
// ----------------------------------------------------------------------------
// Usage. Each transfer on i_btn is one timer tick carrying the levels of the
// mode, up and down buttons. For every tick exactly one transfer leaves on
// o_lvl with the three channel levels, the selected channel, a display
// refresh pulse and a save strobe, in tick order.
// The tick is captured in an input register; the button logic between that
// register and the result register moves it on into the result register,
// from which it is offered on o_lvl. One tick per cycle is sustained while
// the receiver keeps o_lvl.ready high: the input register is refilled in the
// same cycle that its tick moves into the result register.
// When the receiver stalls, the result register holds its transfer and the
// input register takes one more tick; only when both are full is i_btn.ready
// low. The state is updated as a tick moves to the result register, so a
// stall never drops or repeats a tick.
// Reset (i_rst_n low at a clock edge) empties both registers, clears levels,
// mode and hold counters, arms the first display refresh and restores the
// configuration registers to their defaults.
// Configuration writes through i_cfg_we/i_cfg_idx/i_cfg_data take effect at
// the next edge and are to be issued only while no tick is in flight.
// ----------------------------------------------------------------------------
module rgb_level_button_adjuster_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [rlba_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [rlba_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    rlba_btn_if.sink                            i_btn,
    rlba_lvl_if.source                          o_lvl
);
    import rlba_pkg::*;

    // Pipeline registers.
    logic      r_in_valid;
    t_btn      r_in_btn;
    logic      r_out_valid;
    t_lvl_item r_out;

    // Block state, updated when a tick advances into the result register.
    logic [MODE_BITS-1:0]  r_mode;
    logic                  r_mode_held;
    t_hold                 r_up;
    t_hold                 r_down;
    logic [LEVEL_BITS-1:0] r_red;
    logic [LEVEL_BITS-1:0] r_green;
    logic [LEVEL_BITS-1:0] r_blue;
    logic                  r_save_pending;
    logic                  r_disp_pending;

    t_cfg                  cfg;
    logic                  adv;
    logic                  mode_edge;
    logic [MODE_BITS-1:0]  n_mode;
    logic [LEVEL_BITS-1:0] sel_level;
    logic [LEVEL_BITS-1:0] up_level;
    logic [LEVEL_BITS-1:0] dn_level;
    t_hold                 n_up;
    t_hold                 n_down;
    logic                  up_rep;
    logic                  dn_rep;
    logic [LEVEL_BITS-1:0] n_red;
    logic [LEVEL_BITS-1:0] n_green;
    logic [LEVEL_BITS-1:0] n_blue;
    logic                  n_save_raw;
    logic                  n_disp;
    logic                  save_now;
    t_lvl_item             n_out;

    rlba_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // A tick moves on when the result register is empty or being emptied.
    assign adv         = r_in_valid && (!r_out_valid || o_lvl.ready);
    assign i_btn.ready = !r_in_valid || adv;

    // A press edge of the mode button steps the selection; the adjust
    // buttons then work on the channel chosen in this very tick.
    assign mode_edge = r_in_btn.mode_button && !r_mode_held;
    assign n_mode    = r_mode + MODE_BITS'(mode_edge);

    always_comb begin
        case (n_mode)
            MODE_RED:   sel_level = r_red;
            MODE_GREEN: sel_level = r_green;
            MODE_BLUE:  sel_level = r_blue;
            default:    sel_level = '0;
        endcase
    end

    // Up is applied first; down sees the level that up has left.
    rlba_adjust u_up (
        .i_pressed (r_in_btn.up_button),
        .i_dir_up  (1'b1),
        .i_hold    (r_up),
        .i_level   (sel_level),
        .i_cfg     (cfg),
        .o_hold    (n_up),
        .o_level   (up_level),
        .o_repeat  (up_rep)
    );

    rlba_adjust u_down (
        .i_pressed (r_in_btn.down_button),
        .i_dir_up  (1'b0),
        .i_hold    (r_down),
        .i_level   (up_level),
        .i_cfg     (cfg),
        .o_hold    (n_down),
        .o_level   (dn_level),
        .o_repeat  (dn_rep)
    );

    always_comb begin
        n_red   = r_red;
        n_green = r_green;
        n_blue  = r_blue;
        case (n_mode)
            MODE_RED:   n_red   = dn_level;
            MODE_GREEN: n_green = dn_level;
            MODE_BLUE:  n_blue  = dn_level;
            default: begin
            end
        endcase

        // A repeat tick flags a change even when no channel is selected or
        // the move was skipped at the end of the range.
        n_save_raw = r_save_pending || up_rep || dn_rep;
        n_disp     = r_disp_pending || mode_edge || up_rep || dn_rep;
        save_now   = n_save_raw && (n_up.count == '0) && (n_down.count == '0);

        n_out.red_level        = n_red;
        n_out.green_level      = n_green;
        n_out.blue_level       = n_blue;
        n_out.selected_channel = n_mode;
        n_out.refresh_display  = n_disp;
        n_out.save_values      = save_now;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_mode         <= MODE_NONE;
            r_mode_held    <= 1'b0;
            r_up           <= '0;
            r_down         <= '0;
            r_red          <= '0;
            r_green        <= '0;
            r_blue         <= '0;
            r_save_pending <= 1'b0;
            r_disp_pending <= 1'b1;
        end else begin
            if (i_btn.ready) begin
                r_in_valid <= i_btn.valid;
            end
            if (adv) begin
                r_out_valid    <= 1'b1;
                r_mode         <= n_mode;
                r_mode_held    <= r_in_btn.mode_button;
                r_up           <= n_up;
                r_down         <= n_down;
                r_red          <= n_red;
                r_green        <= n_green;
                r_blue         <= n_blue;
                r_save_pending <= n_save_raw && !save_now;
                r_disp_pending <= 1'b0;
            end else if (o_lvl.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers, no reset needed.
    always_ff @(posedge i_clk) begin
        if (i_btn.valid && i_btn.ready) begin
            r_in_btn.mode_button <= i_btn.mode_button;
            r_in_btn.up_button   <= i_btn.up_button;
            r_in_btn.down_button <= i_btn.down_button;
        end
        if (adv) begin
            r_out <= n_out;
        end
    end

    assign o_lvl.valid            = r_out_valid;
    assign o_lvl.red_level        = r_out.red_level;
    assign o_lvl.green_level      = r_out.green_level;
    assign o_lvl.blue_level       = r_out.blue_level;
    assign o_lvl.selected_channel = r_out.selected_channel;
    assign o_lvl.refresh_display  = r_out.refresh_display;
    assign o_lvl.save_values      = r_out.save_values;

    // The save strobe is only offered while both hold counters are idle.
    a_save_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.save_values |-> (r_up.count == '0) && (r_down.count == '0))
        else $error("save strobe offered while a hold counter runs");

    // The offered selection always matches the mode state.
    a_mode_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out.selected_channel == r_mode)
        else $error("offered channel differs from mode state");

    // Every tick that advances leaves a result behind.
    a_adv_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> r_out_valid)
        else $error("advanced tick produced no result");

    // The repeat phase stays inside the period.
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_up.phase < PHASE_BITS'(REPEAT_PERIOD)) && (r_down.phase < PHASE_BITS'(REPEAT_PERIOD)))
        else $error("repeat phase outside the period");

    // A pending display refresh is consumed by the tick that reports it.
    a_disp_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> !r_disp_pending)
        else $error("display refresh still pending after a tick");

endmodule

// ===== sim/rgb_level_button_adjuster_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RGB level button adjuster testbench
// Drives button ticks into the adjuster and checks every result transfer
// against a cycle-free model of the levels, mode, refresh and save strobe.
// Directed tests cover mode cycling, repeats with no channel selected,
// skipped moves and the step extremes. A back-pressure test fills the
// block. Random phases then drive press and hold gestures under changing
// idle patterns and register settings.
// ----------------------------------------------------------------------------
module rgb_level_button_adjuster_unit_tb;
    import rlba_pkg::*;

    localparam int  DRAIN_LIMIT  = 2000;
    localparam int  MAX_REPORTS  = 50;
    // Far beyond the slowest correct run.
    localparam longint RUN_LIMIT_NS = 64'd20_000_000;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     cfg_we;
    logic [CFG_IDX_BITS-1:0]  cfg_idx;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    rlba_btn_if btn_if ();
    rlba_lvl_if lvl_if ();

    rgb_level_button_adjuster_unit u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_btn      (btn_if.sink),
        .o_lvl      (lvl_if.source)
    );

    // Free-running clock with an 8 ns period.
    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Level model. It mirrors the state of the block and is advanced once for
    // every tick that is transferred into it.
    // ------------------------------------------------------------------------
    logic [ACCEL_BITS-1:0]      accel_after_reg;
    logic [STEP_BITS-1:0]       fast_step_reg;
    logic [MODE_BITS-1:0]       sel_channel;
    logic                       mode_btn_held;
    logic [HOLD_COUNT_BITS-1:0] up_hold_cnt;
    logic [HOLD_COUNT_BITS-1:0] down_hold_cnt;
    logic [LEVEL_BITS-1:0]      chan_level [3];
    logic                       save_pending;
    logic                       refresh_pending;

    // Results still owed by the block, oldest first.
    t_lvl_item expected_levels [$];

    // Idle percentages for each side and the requested receiver hold-off.
    int tx_idle_pct;
    int rx_idle_pct;
    int rx_hold_request;

    int ticks_sent;
    int results_checked;
    int mismatch_count;

    task automatic reset_level_model();
        accel_after_reg = ACCEL_RESET;
        fast_step_reg   = FAST_STEP_RESET;
        sel_channel     = MODE_NONE;
        mode_btn_held   = 1'b0;
        up_hold_cnt     = '0;
        down_hold_cnt   = '0;
        chan_level[0]   = '0;
        chan_level[1]   = '0;
        chan_level[2]   = '0;
        save_pending    = 1'b0;
        refresh_pending = 1'b1;
    endtask

    // One adjust button: the hold count runs while pressed, and every
    // repeat period the selected level moves unless it would leave 0..255.
    task automatic apply_hold(input logic pressed, inout logic [HOLD_COUNT_BITS-1:0] cnt,
                              input logic dir_up);
        logic [STEP_BITS-1:0]  step_size;
        logic [LEVEL_BITS-1:0] lvl;
        if (!pressed) begin
            cnt = '0;
        end else begin
            cnt = cnt + 1'b1;
            step_size = (cnt > accel_after_reg) ? fast_step_reg : 8'd1;
            if (cnt % REPEAT_PERIOD == 0) begin
                if (sel_channel != MODE_NONE) begin
                    lvl = chan_level[sel_channel - 2'd1];
                    if (dir_up) begin
                        if (lvl <= LEVEL_MAX - step_size)
                            lvl = lvl + step_size;
                    end else if (lvl >= step_size) begin
                        lvl = lvl - step_size;
                    end
                    chan_level[sel_channel - 2'd1] = lvl;
                end
                // The flags are raised even when nothing moved.
                save_pending    = 1'b1;
                refresh_pending = 1'b1;
            end
        end
    endtask

    task automatic predict_levels(input t_btn b);
        t_lvl_item item;
        logic      save_now;
        if (b.mode_button) begin
            if (!mode_btn_held) begin
                mode_btn_held   = 1'b1;
                sel_channel     = sel_channel + 1'b1;
                refresh_pending = 1'b1;
            end
        end else begin
            mode_btn_held = 1'b0;
        end
        // Up goes first; both see the mode as already stepped in this tick.
        apply_hold(b.up_button, up_hold_cnt, 1'b1);
        apply_hold(b.down_button, down_hold_cnt, 1'b0);
        save_now = save_pending && (up_hold_cnt == '0) && (down_hold_cnt == '0);
        item.red_level        = chan_level[0];
        item.green_level      = chan_level[1];
        item.blue_level       = chan_level[2];
        item.selected_channel = sel_channel;
        item.refresh_display  = refresh_pending;
        item.save_values      = save_now;
        expected_levels.push_back(item);
        refresh_pending = 1'b0;
        if (save_now)
            save_pending = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Checking. Every result transfer is compared with the oldest expected
    // result; the report line count is capped to keep the log readable.
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input int got, input int want_val);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("ERROR: result %0d: %s: got %0d, expected %0d",
                     results_checked, what, got, want_val);
    endtask

    always @(posedge clk) begin : check_results
        t_lvl_item want;
        if (rst_n && lvl_if.valid && lvl_if.ready) begin
            if (expected_levels.size() == 0) begin
                report_mismatch("result with no tick outstanding", 1, 0);
            end else begin
                want = expected_levels.pop_front();
                if (lvl_if.red_level !== want.red_level)
                    report_mismatch("red_level", int'(lvl_if.red_level),
                                    int'(want.red_level));
                if (lvl_if.green_level !== want.green_level)
                    report_mismatch("green_level", int'(lvl_if.green_level),
                                    int'(want.green_level));
                if (lvl_if.blue_level !== want.blue_level)
                    report_mismatch("blue_level", int'(lvl_if.blue_level),
                                    int'(want.blue_level));
                if (lvl_if.selected_channel !== want.selected_channel)
                    report_mismatch("selected_channel", int'(lvl_if.selected_channel),
                                    int'(want.selected_channel));
                if (lvl_if.refresh_display !== want.refresh_display)
                    report_mismatch("refresh_display", int'(lvl_if.refresh_display),
                                    int'(want.refresh_display));
                if (lvl_if.save_values !== want.save_values)
                    report_mismatch("save_values", int'(lvl_if.save_values),
                                    int'(want.save_values));
            end
            results_checked++;
        end
    end

    // Receiver side. A requested hold-off is counted down here, cycle by
    // cycle; otherwise ready is dropped at random in rx_idle_pct of cycles.
    always @(posedge clk) begin : drive_ready
        int hold_left;
        if (rx_hold_request > 0) begin
            hold_left       = rx_hold_request;
            rx_hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            lvl_if.ready <= 1'b0;
        end else begin
            lvl_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Sender side. Every task below is entered and left on a rising edge.
    // ------------------------------------------------------------------------

    // Offers one tick, waits for its transfer, predicts its result and then
    // may leave a random gap. Without a gap valid simply stays high, so it is
    // never lowered and raised within one time step.
    task automatic send_tick(input logic m, input logic u, input logic d);
        t_btn b;
        int   gap;
        b.mode_button = m;
        b.up_button   = u;
        b.down_button = d;
        btn_if.valid       <= 1'b1;
        btn_if.mode_button <= m;
        btn_if.up_button   <= u;
        btn_if.down_button <= d;
        do
            @(posedge clk);
        while (!btn_if.ready);
        predict_levels(b);
        ticks_sent++;
        gap = 0;
        while (gap < 8 && $urandom_range(0, 99) < tx_idle_pct)
            gap++;
        if (gap > 0) begin
            // The payload is noise while valid is low.
            btn_if.valid       <= 1'b0;
            btn_if.mode_button <= 1'($urandom_range(0, 1));
            btn_if.up_button   <= 1'($urandom_range(0, 1));
            btn_if.down_button <= 1'($urandom_range(0, 1));
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic hold_buttons(input logic m, input logic u, input logic d, input int n);
        repeat (n) send_tick(m, u, d);
    endtask

    // Stops offering ticks, waits until every owed result has arrived and then
    // goes on watching for anything extra from the two-stage pipe.
    task automatic wait_for_results();
        int waited;
        btn_if.valid <= 1'b0;
        waited = 0;
        while (expected_levels.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        if (expected_levels.size() != 0) begin
            report_mismatch("results never delivered", 0, expected_levels.size());
            expected_levels.delete();
        end
        repeat (4) @(posedge clk);
    endtask

    // Register write; only called once the block is idle. The enable is
    // lowered before the task returns, so consecutive writes never drive it
    // twice in one time step.
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_ACCEL_AFTER)
            accel_after_reg = data[ACCEL_BITS-1:0];
        else if (idx == CFG_FAST_STEP)
            fast_step_reg = data[STEP_BITS-1:0];
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // First tick refreshes the display; mode steps on press edges only and
    // wraps from blue back to none.
    task automatic test_mode_cycle();
        send_tick(1'b0, 1'b0, 1'b0);
        send_tick(1'b1, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0);
        hold_buttons(1'b1, 1'b0, 1'b0, 2);
        send_tick(1'b0, 1'b0, 1'b0);
        send_tick(1'b1, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0);
        send_tick(1'b1, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0);
    endtask

    // A repeat with no channel selected still raises the save and refresh
    // flags, so the release tick strobes a save.
    task automatic test_repeat_without_channel();
        hold_buttons(1'b0, 1'b1, 1'b0, REPEAT_PERIOD);
        send_tick(1'b0, 1'b0, 1'b0);
    endtask

    // Red selected: a decrease at level 0 is skipped, then up and down
    // together move up and straight back within the same tick.
    task automatic test_skipped_move();
        send_tick(1'b1, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0);
        hold_buttons(1'b0, 1'b0, 1'b1, REPEAT_PERIOD);
        send_tick(1'b0, 1'b0, 1'b0);
        hold_buttons(1'b0, 1'b1, 1'b0, 2 * REPEAT_PERIOD);
        hold_buttons(1'b0, 1'b1, 1'b1, REPEAT_PERIOD);
        send_tick(1'b0, 1'b0, 1'b0);
    endtask

    // Largest and smallest steps: with no threshold the first repeat already
    // moves by the fast step, runs into 255 and is skipped there. Then a fast
    // step of zero, written with junk in the upper data bits, moves nothing
    // yet still sets the flags.
    task automatic test_step_extremes();
        write_reg(CFG_ACCEL_AFTER, 16'd0);
        write_reg(CFG_FAST_STEP, 16'd255);
        send_tick(1'b1, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0);
        hold_buttons(1'b0, 1'b1, 1'b0, 3 * REPEAT_PERIOD);
        send_tick(1'b0, 1'b0, 1'b0);
        hold_buttons(1'b0, 1'b0, 1'b1, REPEAT_PERIOD);
        send_tick(1'b0, 1'b0, 1'b0);
        wait_for_results();
        write_reg(CFG_FAST_STEP, 16'hA500);
        hold_buttons(1'b0, 1'b1, 1'b0, REPEAT_PERIOD);
        send_tick(1'b0, 1'b0, 1'b0);
        hold_buttons(1'b0, 1'b0, 1'b1, REPEAT_PERIOD);
        send_tick(1'b0, 1'b0, 1'b0);
        wait_for_results();
    endtask

    // The receiver holds off for a long stretch while ticks keep coming, so
    // both pipeline registers fill and the input is stalled. The sender then
    // pauses until the backlog has drained.
    task automatic test_back_pressure();
        tx_idle_pct     = 0;
        rx_idle_pct     = 0;
        rx_hold_request = 60;
        hold_buttons(1'b0, 1'b1, 1'b0, 2 * REPEAT_PERIOD);
        send_tick(1'b1, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0);
        wait_for_results();
    endtask

    // Random gestures: mostly well-formed presses and holds of random length,
    // with some overlapping holds and a share of pure noise.
    task automatic test_random_gestures(input int n_ticks, input int tx_pct, input int rx_pct);
        int start;
        int kind;
        int len;
        int i;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        start = ticks_sent;
        while (ticks_sent - start < n_ticks) begin
            kind = $urandom_range(0, 9);
            len  = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 160)
                                                 : $urandom_range(1, 40);
            case (kind)
                0, 1: begin
                    hold_buttons(1'b1, 1'b0, 1'b0, $urandom_range(1, 3));
                    send_tick(1'b0, 1'b0, 1'b0);
                end
                2, 3, 4: begin
                    hold_buttons(1'b0, 1'b1, 1'b0, len);
                    send_tick(1'b0, 1'b0, 1'b0);
                end
                5, 6: begin
                    hold_buttons(1'b0, 1'b0, 1'b1, len);
                    send_tick(1'b0, 1'b0, 1'b0);
                end
                7: begin
                    // Overlapping holds with a random offset between them.
                    hold_buttons(1'b0, 1'b1, 1'b0, $urandom_range(0, 12));
                    hold_buttons(1'b0, 1'b1, 1'b1, len);
                    hold_buttons(1'b0, 1'b0, 1'b1, $urandom_range(0, 12));
                    send_tick(1'b0, 1'b0, 1'b0);
                end
                8: begin
                    // Mode presses while a level is held.
                    for (i = 0; i < len; i++)
                        send_tick(($urandom_range(0, 9) == 0), 1'b1, 1'b0);
                    send_tick(1'b0, 1'b0, 1'b0);
                end
                default: begin
                    repeat ($urandom_range(1, 6))
                        send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                  1'($urandom_range(0, 1)));
                end
            endcase
        end
        wait_for_results();
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_idx            = CFG_ACCEL_AFTER;
        cfg_data           = '0;
        btn_if.valid       = 1'b0;
        btn_if.mode_button = 1'b0;
        btn_if.up_button   = 1'b0;
        btn_if.down_button = 1'b0;
        lvl_if.ready       = 1'b0;
        tx_idle_pct        = 29;
        rx_idle_pct        = 73;
        rx_hold_request    = 0;
        ticks_sent         = 0;
        results_checked    = 0;
        mismatch_count     = 0;
        reset_level_model();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, at the reset register values until the step-extremes test writes its own.
        test_mode_cycle();
        test_repeat_without_channel();
        test_skipped_move();
        wait_for_results();
        test_step_extremes();
        test_back_pressure();

        // Random part: sender idles lightly, receiver heavily, with a low
        // threshold so that acceleration is common.
        write_reg(CFG_ACCEL_AFTER, 16'($urandom_range(0, 60)));
        write_reg(CFG_FAST_STEP, 16'($urandom_range(1, 255)));
        test_random_gestures(340, 29, 73);

        // Roles swapped; the largest threshold keeps every move at one.
        write_reg(CFG_ACCEL_AFTER, 16'hFFFF);
        write_reg(CFG_FAST_STEP, 16'd1);
        test_random_gestures(340, 73, 29);

        // No idling at all, random register contents including upper junk.
        write_reg(CFG_ACCEL_AFTER, 16'($urandom_range(0, 40)));
        write_reg(CFG_FAST_STEP, 16'($urandom_range(0, 65535)));
        test_random_gestures(340, 0, 0);

        $display("Run covered %0d button ticks and %0d checked results: mode cycling,",
                 ticks_sent, results_checked);
        $display("skipped moves, step extremes, back-pressure and random holds.");
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #(RUN_LIMIT_NS);
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/rlba_pkg.sv
sv/rlba_btn_if.sv
sv/rlba_lvl_if.sv
sv/rlba_cfg.sv
sv/rlba_adjust.sv
sv/rgb_level_button_adjuster_unit.sv
sim/rgb_level_button_adjuster_unit_tb.sv
